### design/rfp_pkg.sv
package rfp_pkg;

    // Build-time sizes.
    localparam int DEPTH_LOG2     = 10;
    localparam int ELEMENT_BITS   = 32;
    localparam int MAX_READ_BURST = 64;

    localparam int STORE_DEPTH = 1 << DEPTH_LOG2;
    localparam int ADDR_W      = DEPTH_LOG2;
    localparam int PTR_W       = DEPTH_LOG2 + 1;

    // Fixed field widths.
    localparam int MODE_W  = 2;
    localparam int CAP_W   = 4;
    localparam int REQ_W   = 7;
    localparam int COUNT_W = 11;
    localparam int CMP_W   = (PTR_W > REQ_W) ? PTR_W : REQ_W;

    localparam int COUNT_SAT = 1024;

    // The capacity register resets to 10; larger values are clamped to the built depth.
    localparam logic [CAP_W-1:0] CAP_LOG2_RESET = 4'd10;
    localparam int               CAP_LOG2_MAX   = (DEPTH_LOG2 < 15) ? DEPTH_LOG2 : 15;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_PEEK  = 2'd2
    } t_mode;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    typedef struct packed {
        logic                    we;
        logic                    re;
        logic [ADDR_W-1:0]       addr;
        logic [ELEMENT_BITS-1:0] wdata;
    } t_ram_req;

    typedef struct packed {
        logic               strobe;
        logic               data_valid;
        logic               last;
        logic               accepted;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] level;
        logic               empty;
        logic               full;
    } t_result;

endpackage

### design/rfp_ram.sv
module rfp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/rfp_ctrl.sv
module rfp_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rfp_pkg::CAP_W-1:0]           i_cfg_wdata,
    input  logic                                start,
    output logic                                busy,
    input  logic [rfp_pkg::MODE_W-1:0]          i_mode,
    input  logic [rfp_pkg::ELEMENT_BITS-1:0]    i_element,
    input  logic                                i_burst_last,
    input  logic [rfp_pkg::REQ_W-1:0]           i_request_count,
    output rfp_pkg::t_ram_req                   o_ram_req,
    output rfp_pkg::t_result                    o_result
);

    import rfp_pkg::*;

    t_state             r_state, n_state;
    logic [CAP_W-1:0]   r_cap_log2, n_cap_log2;
    logic [PTR_W-1:0]   r_wp, n_wp;
    logic [PTR_W-1:0]   r_rp, n_rp;
    logic [COUNT_W-1:0] r_burst_cnt, n_burst_cnt;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [REQ_W-1:0]   r_remain, n_remain;
    logic [REQ_W-1:0]   r_total, n_total;
    logic               r_strobe, n_strobe;
    logic               r_data_valid, n_data_valid;
    logic               r_last, n_last;
    logic               r_accepted, n_accepted;
    logic [COUNT_W-1:0] r_count, n_count;

    logic [CAP_W-1:0]   cap_lg;
    logic [PTR_W-1:0]   cap;
    logic [ADDR_W-1:0]  mask;
    logic [PTR_W-1:0]   level;
    logic               has_room;
    logic               accept;
    logic [COUNT_W-1:0] burst_inc;
    logic [REQ_W-1:0]   req_c;
    logic [REQ_W-1:0]   n_items;

    // Capacity, fill level and request clamping.
    always_comb begin
        if (r_cap_log2 < CAP_W'(1)) begin
            cap_lg = CAP_W'(1);
        end else if (int'(r_cap_log2) > CAP_LOG2_MAX) begin
            cap_lg = CAP_W'(CAP_LOG2_MAX);
        end else begin
            cap_lg = r_cap_log2;
        end
        cap      = PTR_W'(1) << cap_lg;
        mask     = ADDR_W'(cap - PTR_W'(1));
        level    = r_wp - r_rp;
        has_room = level < cap;
        if (int'(r_burst_cnt) < COUNT_SAT) begin
            burst_inc = r_burst_cnt + COUNT_W'(1);
        end else begin
            burst_inc = r_burst_cnt;
        end
        if (int'(i_request_count) > MAX_READ_BURST) begin
            req_c = REQ_W'(MAX_READ_BURST);
        end else begin
            req_c = i_request_count;
        end
        if (CMP_W'(req_c) > CMP_W'(level)) begin
            n_items = REQ_W'(level);
        end else begin
            n_items = req_c;
        end
    end

    assign accept = start && !busy;

    // Next state.
    always_comb begin
        n_state      = r_state;
        n_cap_log2   = r_cap_log2;
        n_wp         = r_wp;
        n_rp         = r_rp;
        n_burst_cnt  = r_burst_cnt;
        n_rd_ptr     = r_rd_ptr;
        n_remain     = r_remain;
        n_total      = r_total;
        n_strobe     = 1'b0;
        n_data_valid = 1'b0;
        n_last       = 1'b0;
        n_accepted   = 1'b0;
        n_count      = r_count;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_strobe = 1'b1;
                    n_last   = 1'b1;
                    n_count  = '0;
                    case (t_mode'(i_mode))
                        MODE_WRITE: begin
                            if (has_room) begin
                                n_wp       = r_wp + PTR_W'(1);
                                n_accepted = 1'b1;
                                n_count    = burst_inc;
                            end else begin
                                n_count = r_burst_cnt;
                            end
                            n_burst_cnt = i_burst_last ? '0 : n_count;
                        end
                        MODE_READ, MODE_PEEK: begin
                            if (n_items != '0) begin
                                // The results come from the read sequence instead.
                                n_strobe = 1'b0;
                                n_last   = 1'b0;
                                n_state  = ST_READ;
                                n_rd_ptr = r_rp;
                                n_remain = n_items;
                                n_total  = n_items;
                                if (t_mode'(i_mode) == MODE_READ) begin
                                    n_rp = r_rp + PTR_W'(n_items);
                                end
                            end
                        end
                        default: begin
                            n_count = '0;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_rd_ptr     = r_rd_ptr + PTR_W'(1);
                n_remain     = r_remain - REQ_W'(1);
                n_strobe     = 1'b1;
                n_data_valid = 1'b1;
                n_last       = (r_remain == REQ_W'(1));
                n_count      = COUNT_W'(r_total);
                if (r_remain == REQ_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A capacity write empties the FIFO.
        if (i_cfg_we) begin
            n_cap_log2  = i_cfg_wdata;
            n_wp        = '0;
            n_rp        = '0;
            n_burst_cnt = '0;
        end
    end

    // Outputs.
    always_comb begin
        busy          = (r_state == ST_READ);
        o_ram_req.re  = (r_state == ST_READ);
        o_ram_req.we  = accept && (t_mode'(i_mode) == MODE_WRITE) && has_room;
        o_ram_req.wdata = i_element;
        if (r_state == ST_READ) begin
            o_ram_req.addr = r_rd_ptr[ADDR_W-1:0] & mask;
        end else begin
            o_ram_req.addr = r_wp[ADDR_W-1:0] & mask;
        end

        o_result.strobe     = r_strobe;
        o_result.data_valid = r_data_valid;
        o_result.last       = r_last;
        o_result.accepted   = r_accepted;
        o_result.count      = r_count;
        o_result.level      = COUNT_W'(level);
        o_result.empty      = (level == '0);
        o_result.full       = (level == cap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap_log2  <= CAP_LOG2_RESET;
            r_wp        <= '0;
            r_rp        <= '0;
            r_burst_cnt <= '0;
            r_remain    <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cap_log2  <= n_cap_log2;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_burst_cnt <= n_burst_cnt;
            r_remain    <= n_remain;
            r_strobe    <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr     <= n_rd_ptr;
        r_total      <= n_total;
        r_data_valid <= n_data_valid;
        r_last       <= n_last;
        r_accepted   <= n_accepted;
        r_count      <= n_count;
    end

endmodule

### design/ring_fifo_with_peek.sv
// Channel    Direction  Handshake                    Word
// ---------  ---------  ---------------------------  ---------------------------------------
// command    in         start high while busy low    mode, element, burst_last, request_count
// result     out        o_strobe for one cycle       element, flags, counts, fill level
// config     in         i_cfg_we for one cycle       capacity_log2
//
// A write command never raises busy, and its single result word appears in the
// next cycle; writes can be issued every cycle. A read or peek that delivers n words
// keeps busy high through its read sequence, one buffer memory read per cycle, and the words come
// out one per cycle, each in the cycle after its memory read. A command that delivers
// nothing answers with one word in the next cycle. The receiver cannot stall the
// result channel. Reset is synchronous and active low and leaves the FIFO empty with
// the full 1024-word capacity; the buffer contents are not cleared.
module ring_fifo_with_peek (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rfp_pkg::CAP_W-1:0]           i_cfg_wdata,
    input  logic                                start,
    output logic                                busy,
    input  logic [rfp_pkg::MODE_W-1:0]          i_mode,
    input  logic [rfp_pkg::ELEMENT_BITS-1:0]    i_element,
    input  logic                                i_burst_last,
    input  logic [rfp_pkg::REQ_W-1:0]           i_request_count,
    output logic                                o_strobe,
    output logic [rfp_pkg::ELEMENT_BITS-1:0]    o_read_element,
    output logic                                o_data_valid,
    output logic                                o_is_last,
    output logic                                o_accepted,
    output logic [rfp_pkg::COUNT_W-1:0]         o_transferred_count,
    output logic [rfp_pkg::COUNT_W-1:0]         o_fill_level,
    output logic                                o_is_empty,
    output logic                                o_is_full
);

    import rfp_pkg::*;

    t_ram_req                ram_req;
    t_result                 result;
    logic [ELEMENT_BITS-1:0] ram_rdata;

    // The controller owns the pointers, the burst counter and the read sequence.
    rfp_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_element       (i_element),
        .i_burst_last    (i_burst_last),
        .i_request_count (i_request_count),
        .o_ram_req       (ram_req),
        .o_result        (result)
    );

    // Single-port buffer memory: writes happen while idle, reads only while busy.
    rfp_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_re    (ram_req.re),
        .i_addr  (ram_req.addr),
        .i_wdata (ram_req.wdata),
        .o_rdata (ram_rdata)
    );

    // The memory output register lines up with the result flags, so the element
    // is taken straight from it; words without data show zero.
    assign o_strobe            = result.strobe;
    assign o_read_element      = result.data_valid ? ram_rdata : '0;
    assign o_data_valid        = result.data_valid;
    assign o_is_last           = result.last;
    assign o_accepted          = result.accepted;
    assign o_transferred_count = result.count;
    assign o_fill_level        = result.level;
    assign o_is_empty          = result.empty;
    assign o_is_full           = result.full;

endmodule

### design/rfp_checker.sv
module rfp_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic [rfp_pkg::MODE_W-1:0]          i_mode,
    input logic                                o_strobe,
    input logic                                o_data_valid,
    input logic                                o_is_last,
    input logic                                o_accepted,
    input logic                                o_is_empty
);

    import rfp_pkg::*;

    // Busy is only raised by an accepted read or peek.
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start) && !$past(busy) &&
                        ($past(i_mode) == MODE_READ || $past(i_mode) == MODE_PEEK))
        else $error("busy rose without a read or peek command");

    // A write command answers in the next cycle with a word that has no data.
    a_write_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_mode == MODE_WRITE |=> o_strobe && !o_data_valid && o_is_last)
        else $error("write command without its result word");

    // Data words only while a read sequence runs or just after it.
    a_data_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_data_valid |-> $past(busy))
        else $error("data word outside a read sequence");

    // Busy holds until the last data word of a sequence; every earlier data word comes while busy is high.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_data_valid && !o_is_last |-> busy)
        else $error("read sequence ended before its last word");

    // A stored element cannot leave the FIFO empty.
    a_accept_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_accepted |-> !o_is_empty)
        else $error("element stored but FIFO reports empty");

endmodule

bind ring_fifo_with_peek rfp_checker u_rfp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_mode       (i_mode),
    .o_strobe     (o_strobe),
    .o_data_valid (o_data_valid),
    .o_is_last    (o_is_last),
    .o_accepted   (o_accepted),
    .o_is_empty   (o_is_empty)
);

### tb/ring_fifo_with_peek_test.sv
`timescale 1ns / 100ps

module ring_fifo_with_peek_test;
    import rfp_pkg::*;

    // Mode 3 has no member in the package enum, but the port lets it through.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Cycles allowed for the block to settle once the last word has arrived.
    localparam int SETTLE_CYCLES = 4;
    // Upper bound on waiting for outstanding words before giving up on them.
    localparam int DRAIN_LIMIT   = 4000;
    // Only the first few mismatches are printed; all of them are counted.
    localparam int REPORT_LIMIT  = 30;
    localparam int PLAN_ROWS     = 24;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 37;
    // Small capacity used for the fill-to-full burst.
    localparam logic [CAP_W-1:0] FILL_CAP_LOG2 = 4'd3;

    // One result word as the block presents it on its output ports.
    typedef struct packed {
        logic [ELEMENT_BITS-1:0] data;
        logic                    valid;
        logic                    last;
        logic                    acc;
        logic [COUNT_W-1:0]      count;
        logic [COUNT_W-1:0]      level;
        logic                    empty;
        logic                    full;
    } t_fifo_word;

    // One line of the directed plan: either a capacity write or a command. A command
    // may carry a typed-in answer, which then replaces the predicted word.
    typedef struct {
        bit                      is_cfg;
        logic [CAP_W-1:0]        cap_log2;
        logic [MODE_W-1:0]       mode;
        logic [ELEMENT_BITS-1:0] element;
        logic                    last;
        logic [REQ_W-1:0]        req;
        bit                      pinned;
        t_fifo_word              word;
    } t_plan_row;

    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    i_cfg_we        = 1'b0;
    logic [CAP_W-1:0]        i_cfg_wdata     = '0;
    logic                    start           = 1'b0;
    logic                    busy;
    logic [MODE_W-1:0]       i_mode          = MODE_WRITE;
    logic [ELEMENT_BITS-1:0] i_element       = '0;
    logic                    i_burst_last    = 1'b0;
    logic [REQ_W-1:0]        i_request_count = '0;
    logic                    o_strobe;
    logic [ELEMENT_BITS-1:0] o_read_element;
    logic                    o_data_valid;
    logic                    o_is_last;
    logic                    o_accepted;
    logic [COUNT_W-1:0]      o_transferred_count;
    logic [COUNT_W-1:0]      o_fill_level;
    logic                    o_is_empty;
    logic                    o_is_full;

    ring_fifo_with_peek dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .start              (start),
        .busy               (busy),
        .i_mode             (i_mode),
        .i_element          (i_element),
        .i_burst_last       (i_burst_last),
        .i_request_count    (i_request_count),
        .o_strobe           (o_strobe),
        .o_read_element     (o_read_element),
        .o_data_valid       (o_data_valid),
        .o_is_last          (o_is_last),
        .o_accepted         (o_accepted),
        .o_transferred_count(o_transferred_count),
        .o_fill_level       (o_fill_level),
        .o_is_empty         (o_is_empty),
        .o_is_full          (o_is_full)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the FIFO. It starts in the reset state and follows every
    // accepted command and every capacity write seen on the ports.
    logic [ELEMENT_BITS-1:0] shadow_store [STORE_DEPTH];
    logic [PTR_W-1:0]        shadow_wr       = '0;
    logic [PTR_W-1:0]        shadow_rd       = '0;
    logic [COUNT_W-1:0]      shadow_burst    = '0;
    logic [CAP_W-1:0]        shadow_cap_log2 = CAP_LOG2_RESET;

    // Words still owed by the block, oldest first.
    t_fifo_word awaited_words [$];
    // Typed-in answers, keyed by the number of the command they belong to.
    t_fifo_word pinned_words [int];

    int errors          = 0;
    int issued_count    = 0;
    int accepted_count  = 0;
    int words_checked   = 0;
    int dropped_writes  = 0;
    int capacity_writes = 0;

    t_plan_row directed_plan [PLAN_ROWS];

    // The register holds four bits, but the usable capacity is clamped to 2..1024.
    function automatic int shadow_capacity();
        int lg;
        lg = shadow_cap_log2;
        if (lg < 1) lg = 1;
        if (lg > DEPTH_LOG2) lg = DEPTH_LOG2;
        return 1 << lg;
    endfunction

    // The pointers run one bit wider than the store, so the level is a plain
    // difference that wraps at the pointer width.
    function automatic logic [PTR_W-1:0] shadow_level();
        return shadow_wr - shadow_rd;
    endfunction

    // Builds a word whose status fields reflect the shadow FIFO as it stands now.
    function automatic t_fifo_word status_word(logic [ELEMENT_BITS-1:0] data, logic valid,
                                               logic last, logic acc, int count);
        t_fifo_word w;
        logic [PTR_W-1:0] lvl;
        lvl     = shadow_level();
        w.data  = data;
        w.valid = valid;
        w.last  = last;
        w.acc   = acc;
        w.count = COUNT_W'(count);
        w.level = COUNT_W'(lvl);
        w.empty = (lvl == 0);
        w.full  = (int'(lvl) == shadow_capacity());
        return w;
    endfunction

    // Applies one accepted command to the shadow FIFO and queues the words it owes.
    task automatic compute_fifo_words(logic [MODE_W-1:0] mode, logic [ELEMENT_BITS-1:0] elem,
                                      logic last, logic [REQ_W-1:0] req);
        int cap;
        int n;
        logic [PTR_W-1:0] first;
        logic [PTR_W-1:0] lvl;
        logic acc;
        cap = shadow_capacity();
        lvl = shadow_level();
        case (mode)
            MODE_WRITE: begin
                acc = 1'b0;
                if (int'(lvl) < cap) begin
                    shadow_store[shadow_wr[ADDR_W-1:0] & ADDR_W'(cap - 1)] = elem;
                    shadow_wr = shadow_wr + 1'b1;
                    acc = 1'b1;
                    // The burst tally sticks at its ceiling rather than wrapping.
                    if (shadow_burst < COUNT_SAT) shadow_burst = shadow_burst + 1'b1;
                end else begin
                    dropped_writes++;
                end
                awaited_words.push_back(status_word('0, 1'b0, 1'b1, acc, shadow_burst));
                if (last) shadow_burst = '0;
            end
            MODE_READ, MODE_PEEK: begin
                n = req;
                if (n > MAX_READ_BURST) n = MAX_READ_BURST;
                if (n > int'(lvl)) n = lvl;
                if (n == 0) begin
                    // Nothing to hand out still earns one closing word.
                    awaited_words.push_back(status_word('0, 1'b0, 1'b1, 1'b0, 0));
                end else begin
                    first = shadow_rd;
                    // A read moves the out pointer before the words go out, so
                    // every one of them reports the level after the removal.
                    if (mode == MODE_READ) shadow_rd = shadow_rd + PTR_W'(n);
                    for (int i = 0; i < n; i++) begin
                        awaited_words.push_back(status_word(
                            shadow_store[(first[ADDR_W-1:0] + ADDR_W'(i)) & ADDR_W'(cap - 1)],
                            1'b1, i == n - 1, 1'b0, n));
                    end
                end
            end
            default: begin
                awaited_words.push_back(status_word('0, 1'b0, 1'b1, 1'b0, 0));
            end
        endcase
    endtask

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_word(t_fifo_word want, t_fifo_word got);
        compare_field("read_element", want.data, got.data);
        compare_field("data_valid", want.valid, got.valid);
        compare_field("is_last", want.last, got.last);
        compare_field("accepted", want.acc, got.acc);
        compare_field("transferred_count", want.count, got.count);
        compare_field("fill_level", want.level, got.level);
        compare_field("is_empty", want.empty, got.empty);
        compare_field("is_full", want.full, got.full);
    endtask

    // Everything is sampled at the rising edge, where the driver's nonblocking
    // updates and the block's own register updates have not landed yet, so each
    // value seen here is the one that held during the cycle that just ended.
    always @(posedge i_clk) begin : result_monitor
        t_fifo_word got;
        if (i_rst_n) begin
            // Results of a command accepted at this edge appear no earlier than the
            // next cycle, so the check comes before the new prediction.
            if (o_strobe) begin
                got = '{o_read_element, o_data_valid, o_is_last, o_accepted,
                        o_transferred_count, o_fill_level, o_is_empty, o_is_full};
                if (awaited_words.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("%0t: unexpected word, expected none, actual %0h",
                                 $time, got);
                end else begin
                    check_word(awaited_words.pop_front(), got);
                    words_checked++;
                end
            end
            if (i_cfg_we) begin
                // A capacity change also empties the FIFO and ends any burst.
                shadow_cap_log2 = i_cfg_wdata;
                shadow_wr       = '0;
                shadow_rd       = '0;
                shadow_burst    = '0;
                capacity_writes++;
            end
            if (start && !busy) begin
                compute_fifo_words(i_mode, i_element, i_burst_last, i_request_count);
                // A directed row with a typed-in answer always owes exactly one word.
                if (pinned_words.exists(accepted_count)) begin
                    void'(awaited_words.pop_back());
                    awaited_words.push_back(pinned_words[accepted_count]);
                    pinned_words.delete(accepted_count);
                end
                accepted_count++;
            end
        end
    end

    // Mostly back to back, now and then a short pause, rarely a long one.
    function automatic int rand_gap(bit idle_ok);
        int pick;
        if (!idle_ok) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 65) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Presents one command and holds it until the block takes it. The driver
    // runs right after a rising edge, so busy still shows the value that the
    // block's acceptance decision at that edge was based on.
    task automatic issue(logic [MODE_W-1:0] mode, logic [ELEMENT_BITS-1:0] elem, logic last,
                         logic [REQ_W-1:0] req, bit pinned, t_fifo_word pin, int gap);
        if (pinned) pinned_words[issued_count] = pin;
        issued_count++;
        start           <= 1'b1;
        i_mode          <= mode;
        i_element       <= elem;
        i_burst_last    <= last;
        i_request_count <= req;
        do @(posedge i_clk); while (busy);
        // With no gap, start stays high and the next command follows at once.
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Lowers start and waits, within a bound, until the block owes nothing more.
    task automatic wait_idle();
        int waited;
        waited = 0;
        start <= 1'b0;
        @(posedge i_clk);
        while (awaited_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (awaited_words.size() != 0) begin
            errors++;
            $display("%0t: %0d expected words never arrived", $time, awaited_words.size());
            awaited_words.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The capacity register is only touched while the block sits idle.
    task automatic write_capacity(logic [CAP_W-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic issue_random(bit idle_ok);
        logic [MODE_W-1:0] mode;
        logic [REQ_W-1:0]  req;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 48)      mode = MODE_WRITE;
        else if (pick < 73) mode = MODE_READ;
        else if (pick < 92) mode = MODE_PEEK;
        else                mode = MODE_UNUSED;
        // Requests are mostly small so the level keeps moving in both directions;
        // zero and values past the burst limit show up now and then.
        pick = $urandom_range(0, 99);
        if (pick < 60)      req = REQ_W'($urandom_range(1, 4));
        else if (pick < 85) req = REQ_W'($urandom_range(1, MAX_READ_BURST));
        else if (pick < 92) req = '0;
        else if (pick < 96) req = REQ_W'(MAX_READ_BURST);
        else                req = REQ_W'($urandom_range(MAX_READ_BURST + 1, (1 << REQ_W) - 1));
        issue(mode, $urandom, $urandom_range(0, 99) < 30, req, 1'b0, '0, rand_gap(idle_ok));
    endtask

    function automatic t_plan_row cmd_row(logic [MODE_W-1:0] mode,
                                          logic [ELEMENT_BITS-1:0] elem, logic last,
                                          logic [REQ_W-1:0] req);
        t_plan_row r;
        r          = '{default: '0};
        r.mode     = mode;
        r.element  = elem;
        r.last     = last;
        r.req      = req;
        return r;
    endfunction

    function automatic t_plan_row pin_row(logic [MODE_W-1:0] mode,
                                          logic [ELEMENT_BITS-1:0] elem, logic last,
                                          logic [REQ_W-1:0] req, t_fifo_word w);
        t_plan_row r;
        r        = cmd_row(mode, elem, last, req);
        r.pinned = 1'b1;
        r.word   = w;
        return r;
    endfunction

    function automatic t_plan_row cfg_row(logic [CAP_W-1:0] value);
        t_plan_row r;
        r          = '{default: '0};
        r.is_cfg   = 1'b1;
        r.cap_log2 = value;
        return r;
    endfunction

    // Every typed-in answer is a single closing word with no data, so only the
    // accepted flag, the count and the level flags need to be spelled out.
    function automatic t_fifo_word flags_word(int acc, int count, int level,
                                              int empty, int full);
        return '{'0, 1'b0, 1'b1, 1'(acc), COUNT_W'(count), COUNT_W'(level),
                 1'(empty), 1'(full)};
    endfunction

    initial begin
        int phase_caps [RANDOM_PHASES];

        // Directed plan. It starts from the reset capacity of 1024 words.
        directed_plan = '{
            // Empty FIFO: read, peek and the unused mode all close with one bare word.
            pin_row(MODE_READ,   32'h0000_0000, 1'b0, 7'd1,   flags_word(0, 0, 0, 1, 0)),
            pin_row(MODE_PEEK,   32'hFFFF_FFFF, 1'b1, 7'd64,  flags_word(0, 0, 0, 1, 0)),
            pin_row(MODE_UNUSED, 32'h0000_0000, 1'b0, 7'd0,   flags_word(0, 0, 0, 1, 0)),
            // A burst of three, then a burst of one; the tally restarts after each end.
            pin_row(MODE_WRITE,  32'hFFFF_FFFF, 1'b0, 7'd127, flags_word(1, 1, 1, 0, 0)),
            pin_row(MODE_WRITE,  32'h0000_0000, 1'b0, 7'd0,   flags_word(1, 2, 2, 0, 0)),
            pin_row(MODE_WRITE,  32'hA5A5_A5A5, 1'b1, 7'd1,   flags_word(1, 3, 3, 0, 0)),
            pin_row(MODE_WRITE,  32'h5A5A_5A5A, 1'b1, 7'd1,   flags_word(1, 1, 4, 0, 0)),
            // Peeks leave the data in place; a full-size peek stops at the level.
            cmd_row(MODE_PEEK,   32'h0000_0000, 1'b0, 7'd2),
            cmd_row(MODE_PEEK,   32'h0000_0000, 1'b0, 7'd64),
            cmd_row(MODE_READ,   32'h0000_0000, 1'b0, 7'd1),
            // The unused mode with every other field high changes nothing.
            pin_row(MODE_UNUSED, 32'hFFFF_FFFF, 1'b1, 7'd127, flags_word(0, 0, 3, 0, 0)),
            // A request past the burst limit is cut to the limit, then to the level.
            cmd_row(MODE_READ,   32'h0000_0000, 1'b0, 7'd127),
            pin_row(MODE_READ,   32'h0000_0000, 1'b0, 7'd0,   flags_word(0, 0, 0, 1, 0)),
            // Capacity zero is taken as two words; the third write is dropped.
            cfg_row(4'd0),
            pin_row(MODE_WRITE,  32'h0000_0001, 1'b0, 7'd1,   flags_word(1, 1, 1, 0, 0)),
            pin_row(MODE_WRITE,  32'h0000_0002, 1'b0, 7'd1,   flags_word(1, 2, 2, 0, 1)),
            pin_row(MODE_WRITE,  32'h0000_0003, 1'b1, 7'd1,   flags_word(0, 2, 2, 0, 1)),
            // A zero request delivers nothing even with data waiting.
            pin_row(MODE_PEEK,   32'h0000_0000, 1'b0, 7'd0,   flags_word(0, 0, 2, 0, 1)),
            cmd_row(MODE_READ,   32'h0000_0000, 1'b0, 7'd64),
            // Capacity fifteen is clamped to the built depth.
            cfg_row(4'd15),
            pin_row(MODE_WRITE,  32'h0000_0007, 1'b0, 7'd1,   flags_word(1, 1, 1, 0, 0)),
            // A capacity change drops the stored word and the open burst tally.
            cfg_row(4'd4),
            pin_row(MODE_READ,   32'h0000_0000, 1'b0, 7'd5,   flags_word(0, 0, 0, 1, 0)),
            pin_row(MODE_WRITE,  32'h0000_0009, 1'b1, 7'd1,   flags_word(1, 1, 1, 0, 0))
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].is_cfg) begin
                write_capacity(directed_plan[i].cap_log2);
            end else begin
                issue(directed_plan[i].mode, directed_plan[i].element, directed_plan[i].last,
                      directed_plan[i].req, directed_plan[i].pinned, directed_plan[i].word,
                      rand_gap(1'b1));
            end
        end

        // Fill an eight-word FIFO in one unbroken burst, then keep the burst open
        // past full so that a write is dropped while the tally holds.
        write_capacity(FILL_CAP_LOG2);
        repeat (1 << FILL_CAP_LOG2) issue(MODE_WRITE, $urandom, 1'b0, 7'd1, 1'b0, '0, 0);
        issue(MODE_WRITE, $urandom, 1'b0, 7'd1, 1'b0, '0, rand_gap(1'b1));
        issue(MODE_READ, $urandom, 1'b0, 7'd1, 1'b0, '0, rand_gap(1'b1));
        issue(MODE_WRITE, $urandom, 1'b1, 7'd1, 1'b0, '0, rand_gap(1'b1));
        issue(MODE_PEEK, $urandom, 1'b0, 7'd64, 1'b0, '0, rand_gap(1'b1));
        issue(MODE_READ, $urandom, 1'b0, 7'd64, 1'b0, '0, rand_gap(1'b1));

        // Random phases, mostly at small capacities so that the FIFO fills,
        // wraps and empties often. Every third phase runs without pauses.
        phase_caps = '{4'd2, 4'd1, 4'($urandom_range(0, 15)), 4'd3, 4'd0};
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_capacity(CAP_W'(phase_caps[p]));
            repeat (PHASE_ITEMS) issue_random((p % 3) != 2);
        end

        wait_idle();
        $display("Covered %0d commands, %0d result words, %0d dropped writes,",
                 accepted_count, words_checked, dropped_writes);
        $display("and %0d capacity changes across clamped, small and full-depth settings.",
                 capacity_writes);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Safety net far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

### files.f
design/rfp_pkg.sv
design/rfp_ram.sv
design/rfp_ctrl.sv
design/ring_fifo_with_peek.sv
design/rfp_checker.sv
tb/ring_fifo_with_peek_test.sv
